// File: hw/rtl/hrp_pkg.sv
package hrp_pkg;

    // Default width of the byte counter taken from the header.
    localparam int COUNT_BITS_DEF = 24;

    // Parser phases.
    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_START      = 3'd1;
    localparam logic [2:0] PH_TYPE_FIRST = 3'd2;
    localparam logic [2:0] PH_TYPE_REST  = 3'd3;
    localparam logic [2:0] PH_SPACES     = 3'd4;
    localparam logic [2:0] PH_COUNT      = 3'd5;
    localparam logic [2:0] PH_DATA       = 3'd6;

    // Result status codes.
    localparam logic [1:0] ST_DATA  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;
    localparam logic [1:0] ST_TRUNC = 2'd3;

    // Characters the header grammar looks for.
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // Decoded lowercase hex digit: valid flag and nibble value.
    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t h;
        h.valid = 1'b0;
        h.value = 4'd0;
        if (c inside {["0":"9"]})
        begin
            h.valid = 1'b1;
            h.value = c[3:0];
        end
        else if (c inside {["a":"f"]})
        begin
            h.valid = 1'b1;
            h.value = c[3:0] + 4'd9;
        end
        return h;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {["A":"Z"], ["a":"z"]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {["0":"9"]});
    endfunction

endpackage

// File: hw/rtl/hrp_in_if.sv
interface hrp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       in_first;
    logic       in_end;

    modport source (output valid, in_char, in_first, in_end, input ready);
    modport sink   (input valid, in_char, in_first, in_end, output ready);
endinterface

// File: hw/rtl/hrp_out_if.sv
interface hrp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic [1:0] out_status;

    modport source (output valid, out_byte, out_last, out_status, input ready);
    modport sink   (input valid, out_byte, out_last, out_status, output ready);
endinterface

// File: hw/rtl/hex_raw_profile_decoder.sv
// Hex text profile decoder.
// in_ch carries one character of profile text per transfer, with in_first
// marking the first character of a profile and in_end the last character
// of the buffer. The header (newline, type letters, newline, optional
// spaces, decimal byte count, newline) is checked, then lowercase hex digit
// pairs are emitted on out_ch as bytes until the count is reached.
// A character causes at most one result: a data byte, or a final result
// (empty profile, bad header, truncated) with out_last set.
// The result is registered and appears on out_ch in the cycle after the input
// transfer, and one character is taken every cycle while the receiver does not
// stall: the parser state and the result register both update in the cycle of
// the transfer. The counter update is one shift-add and a range check on
// COUNT_BITS + 4 bits. Reset puts the parser idle; characters without
// in_first are then dropped with no result. When the receiver stalls, the
// result register holds its item and in_ch takes a new character only in a
// cycle in which that item leaves, so nothing is lost or overwritten.
module hex_raw_profile_decoder #(
    parameter int COUNT_BITS = hrp_pkg::COUNT_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    hrp_in_if.sink       in_ch,
    hrp_out_if.source    out_ch
);
    import hrp_pkg::*;

    localparam int SUM_BITS = COUNT_BITS + 4;

    // Parser state.
    logic [2:0]            phase_reg, phase_next;
    logic [COUNT_BITS-1:0] remaining_reg, remaining_next;
    logic [3:0]            high_nibble_reg, high_nibble_next;
    logic                  have_high_reg, have_high_next;

    // Result register.
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic [1:0] out_status_reg;

    // Result of the current character.
    logic       res_valid;
    logic [7:0] res_byte;
    logic       res_last;
    logic [1:0] res_status;

    logic                in_fire;
    logic [2:0]          cur_phase;
    logic                active;
    logic                done;
    hex_digit_t          hex;
    logic [SUM_BITS-1:0] count_ext;
    logic [SUM_BITS-1:0] count_sum;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;

    assign hex       = hex_decode(in_ch.in_char);
    assign count_ext = {4'd0, remaining_reg};
    assign count_sum = (count_ext << 3) + (count_ext << 1)
                     + {{(SUM_BITS - 4){1'b0}}, in_ch.in_char[3:0]};

    // One parser step for the presented character.
    always_comb
    begin
        cur_phase        = in_ch.in_first ? PH_START : phase_reg;
        phase_next       = cur_phase;
        remaining_next   = in_ch.in_first ? '0 : remaining_reg;
        high_nibble_next = in_ch.in_first ? 4'd0 : high_nibble_reg;
        have_high_next   = in_ch.in_first ? 1'b0 : have_high_reg;
        res_valid        = 1'b0;
        res_byte         = 8'd0;
        res_last         = 1'b0;
        res_status       = ST_DATA;
        active           = 1'b1;
        done             = 1'b0;

        case (cur_phase)
            PH_START:
            begin
                if (in_ch.in_char != CHAR_LF)
                    done = 1'b1;
                else
                    phase_next = PH_TYPE_FIRST;
            end
            PH_TYPE_FIRST:
            begin
                if (!is_alpha(in_ch.in_char))
                    done = 1'b1;
                else
                    phase_next = PH_TYPE_REST;
            end
            PH_TYPE_REST:
            begin
                if (in_ch.in_char == CHAR_LF)
                    phase_next = PH_SPACES;
                else if (!is_alpha(in_ch.in_char))
                    done = 1'b1;
            end
            PH_SPACES:
            begin
                if (is_digit(in_ch.in_char))
                begin
                    remaining_next = {{(COUNT_BITS - 4){1'b0}}, in_ch.in_char[3:0]};
                    phase_next     = PH_COUNT;
                end
                else if (in_ch.in_char != CHAR_SPACE)
                begin
                    done = 1'b1;
                end
            end
            PH_COUNT:
            begin
                if (is_digit(in_ch.in_char))
                begin
                    if (count_sum[SUM_BITS-1:COUNT_BITS] != 4'd0)
                        done = 1'b1;
                    else
                        remaining_next = count_sum[COUNT_BITS-1:0];
                end
                else if (in_ch.in_char == CHAR_LF)
                begin
                    if (remaining_reg == '0)
                    begin
                        done       = 1'b1;
                        res_status = ST_EMPTY;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
                else
                begin
                    done = 1'b1;
                end
            end
            PH_DATA:
            begin
                if (hex.valid)
                begin
                    if (!have_high_reg)
                    begin
                        high_nibble_next = hex.value;
                        have_high_next   = 1'b1;
                    end
                    else
                    begin
                        res_valid        = 1'b1;
                        res_byte         = {high_nibble_reg, hex.value};
                        high_nibble_next = 4'd0;
                        have_high_next   = 1'b0;
                        remaining_next   = remaining_reg - {{(COUNT_BITS - 1){1'b0}}, 1'b1};
                        if (remaining_reg == {{(COUNT_BITS - 1){1'b0}}, 1'b1})
                        begin
                            res_last   = 1'b1;
                            phase_next = PH_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                active = 1'b0;
            end
        endcase

        // Header errors and the empty profile end the profile here.
        if (done)
        begin
            res_valid  = 1'b1;
            res_byte   = 8'd0;
            res_last   = 1'b1;
            if (res_status != ST_EMPTY)
                res_status = ST_BAD;
            phase_next = PH_IDLE;
        end
        // Buffer ends while the profile is still open.
        else if (active && !res_last && in_ch.in_end)
        begin
            res_valid  = 1'b1;
            res_byte   = 8'd0;
            res_last   = 1'b1;
            res_status = ST_TRUNC;
            phase_next = PH_IDLE;
        end
    end

    // Parser state advances on each input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            remaining_reg   <= '0;
            high_nibble_reg <= 4'd0;
            have_high_reg   <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg       <= phase_next;
            remaining_reg   <= remaining_next;
            high_nibble_reg <= high_nibble_next;
            have_high_reg   <= have_high_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= res_valid;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    // Result payload, loaded with each input transfer.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_byte_reg   <= res_byte;
            out_last_reg   <= res_last;
            out_status_reg <= res_status;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.out_byte   = out_byte_reg;
    assign out_ch.out_last   = out_last_reg;
    assign out_ch.out_status = out_status_reg;

    // A final result always leaves the parser idle.
    a_last_idles: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && res_valid && res_last |=> phase_reg == PH_IDLE)
        else $error("parser not idle after a final result");

    // Every status other than data is a final result with a zero byte.
    a_status_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg != ST_DATA |-> out_last_reg && out_byte_reg == 8'd0)
        else $error("non-data status without last or with a byte");

    // The data section never runs with an exhausted count.
    a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> remaining_reg != '0)
        else $error("data phase with zero bytes remaining");

    // A held high nibble exists only in the data section or in idle.
    a_nibble_phase: assert property (@(posedge clk) disable iff (!rst_n)
        have_high_reg |-> phase_reg == PH_DATA || phase_reg == PH_IDLE)
        else $error("high nibble held outside the data section");

endmodule
